// ===== rtl/tmrf_pkg.sv =====
// tmrf_pkg: shared types and constants for the terminated message ring fifo
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tmrf_pkg;

	localparam int unsigned DEFAULT_DEPTH = 256;

	localparam logic MODE_APPEND   = 1'b0;
	localparam logic MODE_RETRIEVE = 1'b1;

	localparam logic [2:0] ST_TAKEN  = 3'd0;
	localparam logic [2:0] ST_COMMIT = 3'd1;
	localparam logic [2:0] ST_DROP   = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_EMPTY  = 3'd4;

	typedef struct packed {
		logic       mode;
		logic [7:0] in_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       message_end;
		logic [2:0] status;
		logic       queue_empty;
	} out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RDWAIT,
		S_OUT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic capture;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_needed;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/tmrf_ctrl.sv =====
// tmrf_ctrl: request sequencing state machine
// depends on tmrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmrf_ctrl
	import tmrf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output dp_cmd_t         cmd,
	input  wire dp_status_t stat
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = stat.rd_needed ? S_RDWAIT : S_OUT;
				end
			end
			S_RDWAIT: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.capture = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_RDWAIT: begin
				cmd.capture = 1'b1;
			end
			S_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.accept = in_valid && in_ready;
	end

endmodule

`default_nettype wire

// ===== rtl/tmrf_datapath.sv =====
// tmrf_datapath: byte ring memory, pointers and result register
// depends on tmrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmrf_datapath
	import tmrf_pkg::*;
#(
	parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire in_t        in_data,
	input  wire dp_cmd_t    cmd,
	output dp_status_t      stat,
	output out_t            out_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] rd_ptr_q, cwp_q, pwp_q;
	logic          ovf_q;
	out_t          out_q;

	logic [AW-1:0] pwp_next, rd_next;
	logic          is_empty, no_room, is_term, do_write;

	always_comb begin
		pwp_next = (pwp_q == LAST) ? '0 : pwp_q + 1'b1;
		rd_next  = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
		is_empty = (rd_ptr_q == cwp_q);
		no_room  = (pwp_next == rd_ptr_q);
		is_term  = (in_data.in_byte == 8'd0);
		do_write = cmd.accept && (in_data.mode == MODE_APPEND) && !ovf_q && !no_room;
		stat.rd_needed = (in_data.mode == MODE_RETRIEVE) && !is_empty;
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[pwp_q] <= in_data.in_byte;
		end
		if (cmd.accept) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			cwp_q    <= '0;
			pwp_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (cmd.accept) begin
			if (in_data.mode == MODE_APPEND) begin
				if (ovf_q) begin
					if (is_term) begin
						ovf_q <= 1'b0;
					end
				end else if (no_room) begin
					pwp_q <= cwp_q;
					ovf_q <= !is_term;
				end else begin
					pwp_q <= pwp_next;
					if (is_term) begin
						cwp_q <= pwp_next;
					end
				end
			end else if (!is_empty) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	// result register, byte of a retrieve filled in during the cycle after the request is accepted
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			out_q.out_byte    <= 8'd0;
			out_q.message_end <= 1'b0;
			if (in_data.mode == MODE_APPEND) begin
				out_q.queue_empty <= (rd_ptr_q == ((do_write && is_term) ? pwp_next : cwp_q));
				if (ovf_q || no_room) begin
					out_q.status <= ST_DROP;
				end else if (is_term) begin
					out_q.status <= ST_COMMIT;
				end else begin
					out_q.status <= ST_TAKEN;
				end
			end else if (is_empty) begin
				out_q.status      <= ST_EMPTY;
				out_q.queue_empty <= 1'b1;
			end else begin
				out_q.status      <= ST_READ;
				out_q.queue_empty <= (rd_next == cwp_q);
			end
		end else if (cmd.capture) begin
			out_q.out_byte    <= rd_data_q;
			out_q.message_end <= (rd_data_q == 8'd0);
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== rtl/terminated_message_ring_fifo.sv =====
// terminated_message_ring_fifo: zero-terminated message ring buffer, drop on overflow
// result: append and empty-queue retrieve go from idle straight to the output state, a retrieve
// of a byte first passes through a read wait state (registered memory read)
// a new request is taken only after the previous result has been accepted at the output
// reset: pointers and drop flag clear asynchronously, ring memory content undefined
`timescale 1ns / 1ps
`default_nettype none

module terminated_message_ring_fifo
	import tmrf_pkg::*;
#(
	parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	dp_cmd_t    cmd;
	dp_status_t stat;

	tmrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tmrf_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ===== tb/terminated_message_ring_fifo_tb.sv =====
`timescale 1ns / 1ps
// terminated_message_ring_fifo_tb: self-checking bench for the message ring fifo, random stalls
// keeps its own copy of the ring and pointers and checks every result in order
// depends on tmrf_pkg and terminated_message_ring_fifo

module terminated_message_ring_fifo_tb;
	import tmrf_pkg::*;

	localparam int unsigned RING_DEPTH = DEFAULT_DEPTH;
	localparam int MAX_GAP = 12;
	localparam int MAX_REPORTS = 10;
	localparam int unsigned DRAIN_LIMIT = 100000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// ring copy, only committed entries are ever read back
	logic [7:0] ring_bytes [RING_DEPTH];
	int unsigned rd_ptr = 0;
	int unsigned commit_ptr = 0;
	int unsigned pend_ptr = 0;
	bit dropping = 1'b0;

	out_t ring_outcomes [$];
	int unsigned mismatch_count = 0;
	int unsigned items_sent = 0;
	bit send_gaps_on = 1'b1;
	bit recv_stalls_on = 1'b1;
	int unsigned hold_cycles = 0;

	terminated_message_ring_fifo #(
		.DEPTH(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned ring_step(int unsigned p);
		return (p + 1 == RING_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic out_t step_ring(in_t req);
		out_t res;
		int unsigned nxt;
		res = '0;
		if (req.mode == MODE_APPEND) begin
			if (dropping) begin
				// rest of a dropped message, its terminator ends the drop
				if (req.in_byte == 8'd0)
					dropping = 1'b0;
				res.status = ST_DROP;
			end else begin
				nxt = ring_step(pend_ptr);
				if (nxt == rd_ptr) begin
					pend_ptr = commit_ptr;
					dropping = (req.in_byte != 8'd0);
					res.status = ST_DROP;
				end else begin
					ring_bytes[pend_ptr] = req.in_byte;
					pend_ptr = nxt;
					if (req.in_byte == 8'd0) begin
						commit_ptr = pend_ptr;
						res.status = ST_COMMIT;
					end else begin
						res.status = ST_TAKEN;
					end
				end
			end
		end else if (rd_ptr == commit_ptr) begin
			res.status = ST_EMPTY;
		end else begin
			res.out_byte = ring_bytes[rd_ptr];
			res.message_end = (ring_bytes[rd_ptr] == 8'd0);
			res.status = ST_READ;
			rd_ptr = ring_step(rd_ptr);
		end
		res.queue_empty = (rd_ptr == commit_ptr);
		return res;
	endfunction

	task automatic send_request(input logic mode, input logic [7:0] data);
		in_t req;
		int gap;
		req.mode = mode;
		req.in_byte = data;
		gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do begin
			@(posedge clk);
		end while (!in_ready);
		ring_outcomes.push_back(step_ring(req));
		items_sent++;
	endtask

	task automatic append_message(input int unsigned len);
		repeat (len) send_request(MODE_APPEND, 8'($urandom_range(1, 255)));
		send_request(MODE_APPEND, 8'd0);
	endtask

	task automatic retrieve_bytes(input int unsigned count);
		repeat (count) send_request(MODE_RETRIEVE, 8'($urandom_range(0, 255)));
	endtask

	task automatic drain_committed();
		while (rd_ptr != commit_ptr)
			retrieve_bytes(1);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic wait_for_outcomes();
		int unsigned waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (ring_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	task automatic test_empty_queue();
		retrieve_bytes(2);
	endtask

	task automatic test_byte_extremes();
		send_request(MODE_APPEND, 8'hFF);
		send_request(MODE_APPEND, 8'h01);
		send_request(MODE_APPEND, 8'h80);
		send_request(MODE_APPEND, 8'h7F);
		send_request(MODE_APPEND, 8'hAA);
		send_request(MODE_APPEND, 8'h55);
		send_request(MODE_APPEND, 8'h00);
		// lone terminator is a message of its own
		send_request(MODE_APPEND, 8'h00);
		retrieve_bytes(9);
	endtask

	task automatic test_uncommitted_bytes();
		send_request(MODE_APPEND, 8'h11);
		send_request(MODE_APPEND, 8'h22);
		retrieve_bytes(1);
		send_request(MODE_APPEND, 8'h00);
		retrieve_bytes(4);
	endtask

	task automatic test_fill_and_drop();
		drain_committed();
		// exactly fills the ring, then one more byte finds no room
		append_message(RING_DEPTH - 2);
		send_request(MODE_APPEND, 8'h33);
		send_request(MODE_APPEND, 8'h44);
		send_request(MODE_APPEND, 8'h00);
		drain_committed();
		retrieve_bytes(1);
		// terminator itself finds no room, no drop state left behind
		append_message(RING_DEPTH - 1);
		append_message(3);
		drain_committed();
		// long message overflows mid-way, tail discarded up to its terminator
		append_message(RING_DEPTH + 44);
		append_message(2);
		drain_committed();
		retrieve_bytes(1);
	endtask

	task automatic test_random_traffic(input int unsigned count);
		int unsigned start;
		int unsigned read_pct;
		int unsigned r;
		int unsigned len;
		start = items_sent;
		while (items_sent - start < count) begin
			if (((items_sent - start) % 100) < 5) begin
				case ($urandom_range(0, 3))
					0: read_pct = 20;
					1: read_pct = 45;
					2: read_pct = 55;
					default: read_pct = 80;
				endcase
				send_gaps_on = ($urandom_range(0, 3) != 0);
				recv_stalls_on = ($urandom_range(0, 3) != 0);
			end
			r = $urandom_range(0, 99);
			if (r < read_pct) begin
				retrieve_bytes($urandom_range(1, 4));
			end else if (r < read_pct + 5) begin
				send_request(MODE_APPEND, 8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 39))
					0: len = $urandom_range(200, 300);
					1, 2, 3, 4: len = $urandom_range(10, 80);
					default: len = $urandom_range(0, 9);
				endcase
				append_message(len);
			end
		end
		send_gaps_on = 1'b1;
		recv_stalls_on = 1'b1;
	endtask

	task automatic test_backpressure();
		wait_for_outcomes();
		send_gaps_on = 1'b0;
		hold_cycles = 200;
		append_message(15);
		retrieve_bytes(20);
		send_gaps_on = 1'b1;
	endtask

	// receiver: random stall before each result, plus long hold when asked
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				stall_left = recv_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result check against the oldest prediction
	initial begin
		out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (ring_outcomes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unrequested result %02h/%0d/%0d/%0d",
							$realtime, out_data.out_byte, out_data.message_end,
							out_data.status, out_data.queue_empty);
				end else begin
					want = ring_outcomes.pop_front();
					if (out_data.out_byte !== want.out_byte ||
							out_data.message_end !== want.message_end ||
							out_data.status !== want.status ||
							out_data.queue_empty !== want.queue_empty) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: want %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
								$realtime, want.out_byte, want.message_end, want.status,
								want.queue_empty, out_data.out_byte, out_data.message_end,
								out_data.status, out_data.queue_empty);
					end
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_byte_extremes();
		test_uncommitted_bytes();
		test_fill_and_drop();
		test_backpressure();
		test_random_traffic(200);
		wait_for_outcomes();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && ring_outcomes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
